>>> design/mlfs_pkg.sv
// Shared types and constants for the magic-length frame splitter.
// Used by every module in the design folder; no dependencies.
package mlfs_pkg;

  localparam logic [31:0] MAGIC_WORD  = 32'h0004_C453;
  localparam int          HEADER_LEN  = 40;
  localparam int          LEN_W       = 25;
  localparam logic [LEN_W-1:0] LIMIT_RESET = 25'd16777216;
  localparam int          QUEUE_DEPTH = 2;
  localparam int          TDATA_W     = 200;
  localparam int          CFG_IDX_W   = 2;
  localparam int          CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_EN = 2'd0,
    CFG_WANT_HIGH = 2'd1,
    CFG_WANT_LOW  = 2'd2,
    CFG_MAX_LEN   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_BODY   = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [31:0]       ch_high;
    logic [31:0]       ch_low;
    logic [31:0]       seq;
    logic [31:0]       tag;
    logic              comp;
    logic [LEN_W-1:0]  len;
    logic              match;
    logic [7:0]        body;
    logic              last;
    logic [31:0]       lost;
  } rec_t;

endpackage

>>> design/magic_length_frame_splitter_top.sv
// Magic-length frame splitter: one byte beat in per cycle, one record out per
// header or body byte. An accepted byte's record goes through the queue and the
// output register; sustained rate is 1 byte per cycle while the queue is not full.
// Reset (rst_n low, synchronous) returns to hunting, clears the lost count and
// the queue, and loads register defaults. Uses mlfs_pkg, front, queue, back.
module magic_length_frame_splitter_top #(
  parameter int QUEUE_DEPTH = mlfs_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // data_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // channel_high, channel_low, sequence_number, time_tag, is_compressed,
  // frame_length, channel_match, body_byte, drop_count, zero pad
  output logic [mlfs_pkg::TDATA_W-1:0]       out_tdata,
  output logic                               out_tuser,  // record_kind
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [mlfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mlfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic           full;
  logic           byte_fire;
  logic           rec_push;
  mlfs_pkg::rec_t rec;
  logic           q_valid;
  mlfs_pkg::rec_t q_rec;
  logic           pop;

  assign in_tready = !full;
  assign byte_fire = in_tvalid && in_tready;

  mlfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (byte_fire),
    .byte_in   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rec_push  (rec_push),
    .rec       (rec)
  );

  mlfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_rec    (q_rec)
  );

  mlfs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rec      (q_rec),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> design/mlfs_front.sv
// Front end: hunts for the magic word, collects the header, checks length
// and emits header and body records. Depends on mlfs_pkg.
module mlfs_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                byte_fire,
  input  logic [7:0]                          byte_in,
  input  logic                                cfg_we,
  input  logic [mlfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlfs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                rec_push,
  output mlfs_pkg::rec_t                      rec
);

  localparam int LW = mlfs_pkg::LEN_W;

  mlfs_pkg::phase_t phase_r, phase_nxt;
  logic [LW-1:0]    pos_r, pos_nxt;
  logic [31:0]      win_r, win_nxt;
  logic [2:0]       fill_r, fill_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [31:0]      chh_r, chh_nxt;
  logic [31:0]      chl_r, chl_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [31:0]      tag_r, tag_nxt;
  logic [31:0]      comp_r, comp_nxt;
  logic [31:0]      lost_r, lost_nxt;
  logic             match_r, match_nxt;

  logic             flt_en_r;
  logic [31:0]      want_hi_r;
  logic [31:0]      want_lo_r;
  logic [LW-1:0]    max_len_r;

  logic [LW-1:0]    pos_inc;
  logic [32:0]      lost_sum;
  logic [2:0]       lost_add;
  logic             last_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flt_en_r  <= 1'b0;
      want_hi_r <= '0;
      want_lo_r <= '0;
      max_len_r <= mlfs_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mlfs_pkg::CFG_FILTER_EN: flt_en_r  <= cfg_data[0];
        mlfs_pkg::CFG_WANT_HIGH: want_hi_r <= cfg_data;
        mlfs_pkg::CFG_WANT_LOW:  want_lo_r <= cfg_data;
        mlfs_pkg::CFG_MAX_LEN:   max_len_r <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  assign pos_inc  = pos_r + LW'(1);
  assign lost_sum = {1'b0, lost_r} + 33'(lost_add);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    chh_nxt   = chh_r;
    chl_nxt   = chl_r;
    seq_nxt   = seq_r;
    tag_nxt   = tag_r;
    comp_nxt  = comp_r;
    match_nxt = match_r;
    lost_add  = 3'd0;
    last_c    = 1'b0;
    rec_push  = 1'b0;
    rec.kind  = mlfs_pkg::KIND_HEADER;
    rec.body  = 8'd0;

    if (byte_fire) begin
      case (phase_r)
        mlfs_pkg::PH_HEADER: begin
          if (pos_r inside {[4:7]})        len_nxt  = {len_r[23:0], byte_in};
          else if (pos_r inside {[8:11]})  chh_nxt  = {chh_r[23:0], byte_in};
          else if (pos_r inside {[12:15]}) chl_nxt  = {chl_r[23:0], byte_in};
          else if (pos_r inside {[16:19]}) seq_nxt  = {seq_r[23:0], byte_in};
          else if (pos_r inside {[24:27]}) tag_nxt  = {tag_r[23:0], byte_in};
          else if (pos_r inside {[32:35]}) comp_nxt = {comp_r[23:0], byte_in};
          pos_nxt = pos_inc;
          if (pos_r == LW'(7)) begin
            if (len_nxt < 32'(mlfs_pkg::HEADER_LEN) || len_nxt > 32'(max_len_r)) begin
              lost_add = 3'd4;
              win_nxt  = len_nxt;
              if (len_nxt == mlfs_pkg::MAGIC_WORD) begin
                pos_nxt  = LW'(4);
                fill_nxt = 3'd0;
              end else begin
                phase_nxt = mlfs_pkg::PH_HUNT;
                fill_nxt  = 3'd4;
              end
            end
          end else if (pos_r == LW'(mlfs_pkg::HEADER_LEN - 1)) begin
            last_c    = (len_r == 32'(mlfs_pkg::HEADER_LEN));
            match_nxt = !flt_en_r || (chh_r == want_hi_r && chl_r == want_lo_r);
            rec_push  = 1'b1;
            if (last_c) begin
              phase_nxt = mlfs_pkg::PH_HUNT;
              fill_nxt  = 3'd0;
              win_nxt   = '0;
            end else begin
              phase_nxt = mlfs_pkg::PH_BODY;
            end
          end
        end
        mlfs_pkg::PH_BODY: begin
          pos_nxt  = pos_inc;
          last_c   = (pos_inc >= len_r[LW-1:0]);
          rec_push = 1'b1;
          rec.kind = mlfs_pkg::KIND_BODY;
          rec.body = byte_in;
          if (last_c) begin
            phase_nxt = mlfs_pkg::PH_HUNT;
            fill_nxt  = 3'd0;
            win_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = mlfs_pkg::PH_HUNT;
          if (fill_r >= 3'd4) begin
            lost_add = 3'd1;
            fill_nxt = 3'd4;
          end else begin
            fill_nxt = fill_r + 3'd1;
          end
          win_nxt = {win_r[23:0], byte_in};
          if (fill_nxt == 3'd4 && win_nxt == mlfs_pkg::MAGIC_WORD) begin
            phase_nxt = mlfs_pkg::PH_HEADER;
            pos_nxt   = LW'(4);
            fill_nxt  = 3'd0;
          end
        end
      endcase
    end

    lost_nxt = lost_sum[32] ? 32'hFFFF_FFFF : lost_sum[31:0];

    rec.ch_high = chh_r;
    rec.ch_low  = chl_r;
    rec.seq     = seq_r;
    rec.tag     = tag_r;
    rec.comp    = (comp_r == 32'd1);
    rec.len     = len_r[LW-1:0];
    rec.match   = match_nxt;
    rec.last    = last_c;
    rec.lost    = lost_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mlfs_pkg::PH_HUNT;
      pos_r   <= '0;
      win_r   <= '0;
      fill_r  <= '0;
      lost_r  <= '0;
      match_r <= 1'b0;
      len_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      lost_r  <= lost_nxt;
      match_r <= match_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chh_r  <= chh_nxt;
    chl_r  <= chl_nxt;
    seq_r  <= seq_nxt;
    tag_r  <= tag_nxt;
    comp_r <= comp_nxt;
  end

  a_lost_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> lost_r >= $past(lost_r))
    else $error("lost count went down");

  a_body_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == mlfs_pkg::PH_BODY |-> pos_r < len_r[LW-1:0])
    else $error("body position reached frame length");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == mlfs_pkg::PH_HUNT |-> fill_r <= 3'd4)
    else $error("hunt window fill out of range");

endmodule

>>> design/mlfs_queue.sv
// Short record queue between parser and output stage.
// Depends on mlfs_pkg for the record type.
module mlfs_queue #(
  parameter int DEPTH = mlfs_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mlfs_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output mlfs_pkg::rec_t q_rec
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mlfs_pkg::rec_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_rec   = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop) rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (push && !do_pop) count_r <= count_r + CW'(1);
      else if (!push && do_pop) count_r <= count_r - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || do_pop)
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> count_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

>>> design/mlfs_back.sv
// Back end: output register that drains the queue and packs each record
// into the master-side stream beat. Depends on mlfs_pkg.
module mlfs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  mlfs_pkg::rec_t                q_rec,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mlfs_pkg::TDATA_W-1:0]  out_tdata,
  output logic                          out_tuser,
  output logic                          out_tlast
);

  logic           valid_r;
  mlfs_pkg::rec_t rec_r;

  assign pop = q_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_tready) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) rec_r <= q_rec;
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = rec_r.kind;
  assign out_tlast  = rec_r.last;
  assign out_tdata  = {5'd0, rec_r.lost, rec_r.body, rec_r.match, rec_r.len,
                       rec_r.comp, rec_r.tag, rec_r.seq, rec_r.ch_low, rec_r.ch_high};

endmodule

>>> dv/tb_magic_length_frame_splitter_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for magic_length_frame_splitter_top: drives byte beats,
// predicts header and body records in-line and compares every output beat.
// Depends on mlfs_pkg and the design folder only.
module tb_magic_length_frame_splitter_top;

  typedef struct packed {
    logic [7:0]     b;
    bit             typed;
    mlfs_pkg::rec_t rec;
  } beat_t;

  typedef struct packed {
    bit                 wr;
    mlfs_pkg::cfg_idx_t idx;
    logic [31:0]        val;
    logic [7:0]         noise;
    logic [31:0]        len;
    logic [31:0]        chh;
    logic [31:0]        chl;
    logic [31:0]        seqn;
    logic [31:0]        tagv;
    logic [31:0]        compw;
    bit                 typed;
    logic               hit;
    logic [31:0]        lost;
  } dir_row_t;

  localparam int NUM_ROWS = 24;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [7:0]                     in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [mlfs_pkg::TDATA_W-1:0]   out_tdata;
  logic                           out_tuser;
  logic                           out_tlast;
  logic                           cfg_we;
  logic [mlfs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mlfs_pkg::CFG_DATA_W-1:0] cfg_data;

  magic_length_frame_splitter_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow
  logic                       filt;
  logic [31:0]                want_h;
  logic [31:0]                want_l;
  logic [mlfs_pkg::LEN_W-1:0] max_len;

  // splitter state
  mlfs_pkg::phase_t ph;
  logic [31:0]      win;
  int unsigned      fill;
  int unsigned      pos;
  logic [31:0]      len_r, chh_r, chl_r, seq_r, tag_r, comp_r, lost_r;
  logic             hit_r;

  beat_t          stream_q[$];
  mlfs_pkg::rec_t rec_q[$];
  beat_t          cur_beat;
  bit             in_fire;
  bit             quiet;
  int unsigned    queued;
  int unsigned    mismatches;

  string field_names [11] = '{"record_kind", "channel_high", "channel_low",
    "sequence_number", "time_tag", "is_compressed", "frame_length",
    "channel_match", "body_byte", "last_of_frame", "drop_count"};

  // wr idx val noise len chh chl seq tag comp typed hit lost
  dir_row_t dir_tab [NUM_ROWS] = '{
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd0, 32'd40, 32'h0, 32'h0, 32'h0, 32'h0,
      32'd1, 1'b1, 1'b1, 32'd0},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd6, 32'd40, '1, '1, '1, '1, 32'd0,
      1'b1, 1'b1, 32'd6},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd0, 32'd41, 32'h1234_5678,
      32'h9ABC_DEF0, 32'd1, 32'h8000_0000, 32'h0000_0100, 1'b0, 1'b0, 32'd0},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd3, 32'd39, 32'd1, 32'd2, 32'd3, 32'd4,
      32'd2, 1'b0, 1'b0, 32'd0},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd0, '1, 32'd5, 32'd6, 32'd7, 32'd8,
      32'd1, 1'b0, 1'b0, 32'd0},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd1, 32'd16777217, 32'd9, 32'd10,
      32'd11, 32'd12, 32'd1, 1'b0, 1'b0, 32'd0},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd0, 32'd47, 32'h0, '1, 32'd7, 32'd9,
      32'h0100_0000, 1'b0, 1'b0, 32'd0},
    '{1'b1, mlfs_pkg::CFG_MAX_LEN, 32'd100, 8'd0, 32'd0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'h0, 1'b0, 1'b0, 32'd0},
    // length bytes repeat the magic word; channel high becomes the new length
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd0, mlfs_pkg::MAGIC_WORD, 32'd60,
      32'h11, 32'h22, 32'h33, 32'd1, 1'b0, 1'b0, 32'd0},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd30, 32'd100, 32'h44, 32'h55, 32'h66,
      32'h77, 32'd1, 1'b0, 1'b0, 32'd0},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd0, 32'd101, 32'h1, 32'h2, 32'h3,
      32'h4, 32'd1, 1'b0, 1'b0, 32'd0},
    '{1'b1, mlfs_pkg::CFG_MAX_LEN, 32'd39, 8'd0, 32'd0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'h0, 1'b0, 1'b0, 32'd0},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd2, 32'd40, 32'h1, 32'h2, 32'h3, 32'h4,
      32'd1, 1'b0, 1'b0, 32'd0},
    '{1'b1, mlfs_pkg::CFG_MAX_LEN, 32'd40, 8'd0, 32'd0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'h0, 1'b0, 1'b0, 32'd0},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd2, 32'd40, 32'h5, 32'h6, 32'h7, 32'h8,
      32'd0, 1'b0, 1'b0, 32'd0},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd0, 32'd41, 32'h5, 32'h6, 32'h7, 32'h8,
      32'd0, 1'b0, 1'b0, 32'd0},
    '{1'b1, mlfs_pkg::CFG_WANT_HIGH, 32'hA5A5_0001, 8'd0, 32'd0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 1'b0, 1'b0, 32'd0},
    '{1'b1, mlfs_pkg::CFG_WANT_LOW, 32'h5A5A_0002, 8'd0, 32'd0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 1'b0, 1'b0, 32'd0},
    '{1'b1, mlfs_pkg::CFG_FILTER_EN, 32'd1, 8'd0, 32'd0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'h0, 1'b0, 1'b0, 32'd0},
    '{1'b1, mlfs_pkg::CFG_MAX_LEN, 32'd16777216, 8'd0, 32'd0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 1'b0, 1'b0, 32'd0},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd2, 32'd44, 32'hA5A5_0001,
      32'h5A5A_0002, 32'd1, 32'd2, 32'd1, 1'b0, 1'b0, 32'd0},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd0, 32'd40, 32'hA5A5_0001,
      32'h5A5A_0003, 32'd1, 32'd2, 32'd1, 1'b0, 1'b0, 32'd0},
    '{1'b0, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd0, 32'd40, 32'hA5A4_0001,
      32'h5A5A_0002, 32'd1, 32'd2, 32'd1, 1'b0, 1'b0, 32'd0},
    '{1'b1, mlfs_pkg::CFG_FILTER_EN, 32'd0, 8'd0, 32'd0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'h0, 1'b0, 1'b0, 32'd0}
  };

  function automatic void add_lost(logic [31:0] n);
    lost_r = (lost_r > 32'hFFFF_FFFF - n) ? 32'hFFFF_FFFF : lost_r + n;
  endfunction

  function automatic void start_header();
    ph   = mlfs_pkg::PH_HEADER;
    pos  = 4;
    fill = 0;
  endfunction

  function automatic mlfs_pkg::rec_t make_rec(mlfs_pkg::kind_t kind, logic [7:0] b,
                                              logic last);
    mlfs_pkg::rec_t r;
    r.kind    = kind;
    r.ch_high = chh_r;
    r.ch_low  = chl_r;
    r.seq     = seq_r;
    r.tag     = tag_r;
    r.comp    = (comp_r == 32'd1);
    r.len     = len_r[mlfs_pkg::LEN_W-1:0];
    r.match   = hit_r;
    r.body    = b;
    r.last    = last;
    r.lost    = lost_r;
    return r;
  endfunction

  // Advances the splitter by one byte; returns 1 when a record comes out.
  function automatic bit split_byte(logic [7:0] b, output mlfs_pkg::rec_t r);
    int unsigned p;
    r = '0;
    case (ph)
      mlfs_pkg::PH_HEADER: begin
        p = pos;
        if (p >= 4 && p < 8) len_r = {len_r[23:0], b};
        else if (p >= 8 && p < 12) chh_r = {chh_r[23:0], b};
        else if (p >= 12 && p < 16) chl_r = {chl_r[23:0], b};
        else if (p >= 16 && p < 20) seq_r = {seq_r[23:0], b};
        else if (p >= 24 && p < 28) tag_r = {tag_r[23:0], b};
        else if (p >= 32 && p < 36) comp_r = {comp_r[23:0], b};
        p++;
        pos = p;
        if (p == 8) begin
          if (len_r < mlfs_pkg::HEADER_LEN || len_r > {7'd0, max_len}) begin
            add_lost(32'd4);
            win = len_r;
            if (win == mlfs_pkg::MAGIC_WORD) begin
              start_header();
            end else begin
              ph   = mlfs_pkg::PH_HUNT;
              fill = 4;
            end
          end
          return 1'b0;
        end
        if (p == mlfs_pkg::HEADER_LEN) begin
          hit_r = !filt || (chh_r == want_h && chl_r == want_l);
          r = make_rec(mlfs_pkg::KIND_HEADER, 8'h00, len_r == mlfs_pkg::HEADER_LEN);
          if (len_r == mlfs_pkg::HEADER_LEN) begin
            ph   = mlfs_pkg::PH_HUNT;
            fill = 0;
            win  = '0;
          end else begin
            ph = mlfs_pkg::PH_BODY;
          end
          return 1'b1;
        end
        return 1'b0;
      end
      mlfs_pkg::PH_BODY: begin
        pos = pos + 1;
        r = make_rec(mlfs_pkg::KIND_BODY, b, pos >= len_r);
        if (pos >= len_r) begin
          ph   = mlfs_pkg::PH_HUNT;
          fill = 0;
          win  = '0;
        end
        return 1'b1;
      end
      default: begin
        ph = mlfs_pkg::PH_HUNT;
        if (fill >= 4) begin
          add_lost(32'd1);
          fill = 4;
        end else begin
          fill++;
        end
        win = {win[23:0], b};
        if (fill == 4 && win == mlfs_pkg::MAGIC_WORD) start_header();
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [10:0][31:0] rec_fields(mlfs_pkg::rec_t r);
    return {32'(r.lost), 32'(r.last), 32'(r.body), 32'(r.match), 32'(r.len),
            32'(r.comp), r.tag, r.seq, r.ch_low, r.ch_high, 32'(r.kind)};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 100)
      $display("%0t: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(negedge clk) begin
    out_tready <= quiet || ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin : monitor
    mlfs_pkg::rec_t      pred;
    mlfs_pkg::rec_t      got;
    mlfs_pkg::rec_t      want;
    logic [10:0][31:0]   gf;
    logic [10:0][31:0]   wf;
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      in_fire = in_tvalid && in_tready;
      if (in_fire) begin
        if (split_byte(in_tdata, pred)) rec_q.push_back(cur_beat.typed ? cur_beat.rec : pred);
      end
      if (out_tvalid && out_tready) begin
        got.kind    = mlfs_pkg::kind_t'(out_tuser);
        got.ch_high = out_tdata[31:0];
        got.ch_low  = out_tdata[63:32];
        got.seq     = out_tdata[95:64];
        got.tag     = out_tdata[127:96];
        got.comp    = out_tdata[128];
        got.len     = out_tdata[153:129];
        got.match   = out_tdata[154];
        got.body    = out_tdata[162:155];
        got.last    = out_tlast;
        got.lost    = out_tdata[194:163];
        if (rec_q.size() == 0) begin
          report_mismatch("record with nothing expected, kind", 32'(out_tuser), 32'd0);
        end else begin
          want = rec_q.pop_front();
          gf = rec_fields(got);
          wf = rec_fields(want);
          for (int f = 0; f < 11; f++)
            if (gf[f] !== wf[f]) report_mismatch(field_names[f], gf[f], wf[f]);
        end
      end
    end
  end

  function automatic bit stall_now();
    return !quiet && ($urandom_range(0, 99) < 34);
  endfunction

  task automatic push_beat(logic [7:0] b, bit typed, mlfs_pkg::rec_t r);
    beat_t bt;
    bt.b     = b;
    bt.typed = typed;
    bt.rec   = r;
    stream_q.push_back(bt);
    queued++;
  endtask

  // Magic, length and (if full) the rest of the header plus the body when the length
  // is in [HEADER_LEN, limit]. The typed record replaces the predicted header.
  task automatic queue_frame(logic [31:0] len, logic [31:0] chh, logic [31:0] chl,
                             logic [31:0] seqn, logic [31:0] tagv, logic [31:0] compw,
                             bit full, bit typed, logic hit, logic [31:0] lost);
    mlfs_pkg::rec_t tr;
    logic [31:0]    w;
    int             i;
    tr.kind    = mlfs_pkg::KIND_HEADER;
    tr.ch_high = chh;
    tr.ch_low  = chl;
    tr.seq     = seqn;
    tr.tag     = tagv;
    tr.comp    = (compw == 32'd1);
    tr.len     = len[mlfs_pkg::LEN_W-1:0];
    tr.match   = hit;
    tr.body    = 8'h00;
    tr.last    = (len == mlfs_pkg::HEADER_LEN);
    tr.lost    = lost;
    for (i = 0; i < (full ? mlfs_pkg::HEADER_LEN : 8); i++) begin
      case (i / 4)
        0: w = mlfs_pkg::MAGIC_WORD;
        1: w = len;
        2: w = chh;
        3: w = chl;
        4: w = seqn;
        6: w = tagv;
        8: w = compw;
        default: w = $urandom;
      endcase
      push_beat(w[31 - 8 * (i % 4) -: 8], typed && i == mlfs_pkg::HEADER_LEN - 1, tr);
    end
    if (full && len >= mlfs_pkg::HEADER_LEN && len <= {7'd0, max_len})
      repeat (len - mlfs_pkg::HEADER_LEN) push_beat(8'($urandom), 1'b0, '0);
  endtask

  task automatic queue_random_traffic(int unsigned n);
    int unsigned stop;
    int unsigned roll;
    logic [31:0] len;
    logic [31:0] chh;
    logic [31:0] chl;
    stop = queued + n;
    while (queued < stop) begin
      roll = $urandom_range(0, 99);
      chh  = $urandom_range(0, 1) ? want_h : $urandom;
      chl  = $urandom_range(0, 1) ? want_l : $urandom;
      if (roll < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 300) : $urandom_range(40, 64);
        queue_frame(len, chh, chl, $urandom, $urandom,
                    $urandom_range(0, 1) ? 32'd1 : $urandom, 1'b1, 1'b0, 1'b0, '0);
      end else if (roll < 80) begin
        case ($urandom_range(0, 2))
          0: len = $urandom_range(0, 39);
          1: len = {7'd0, max_len} + $urandom_range(1, 3);
          default: len = $urandom;
        endcase
        queue_frame(len, chh, chl, $urandom, $urandom, $urandom, 1'b0, 1'b0, 1'b0, '0);
      end else if (roll < 90) begin
        // junk with zeros and partial magic
        if ($urandom_range(0, 1)) begin
          push_beat(8'h00, 1'b0, '0);
          push_beat(8'h04, 1'b0, '0);
          push_beat(8'hC4, 1'b0, '0);
        end
        repeat ($urandom_range(1, 20))
          push_beat(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom), 1'b0, '0);
      end else begin
        // magic followed by a cut-off header
        queue_frame(mlfs_pkg::MAGIC_WORD, chh, chl, $urandom, $urandom, $urandom, 1'b0,
                    1'b0, 1'b0, '0);
        repeat ($urandom_range(0, 45)) push_beat(8'($urandom), 1'b0, '0);
      end
    end
  endtask

  task automatic run_and_drain();
    bit          busy;
    int unsigned guard;
    busy = 1'b0;
    while (stream_q.size() != 0 || busy) begin
      @(negedge clk);
      if (!busy || in_fire) begin
        if (stream_q.size() == 0 || stall_now()) begin
          in_tvalid <= 1'b0;
          busy = 1'b0;
        end else begin
          cur_beat = stream_q.pop_front();
          in_tdata  <= cur_beat.b;
          in_tvalid <= 1'b1;
          busy = 1'b1;
        end
      end
    end
    guard = 0;
    while (rec_q.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(mlfs_pkg::cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      mlfs_pkg::CFG_FILTER_EN: filt = val[0];
      mlfs_pkg::CFG_WANT_HIGH: want_h = val;
      mlfs_pkg::CFG_WANT_LOW:  want_l = val;
      default:                 max_len = val[mlfs_pkg::LEN_W-1:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    dir_row_t row;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    quiet      = 1'b0;
    queued     = 0;
    mismatches = 0;
    filt    = 1'b0;
    want_h  = '0;
    want_l  = '0;
    max_len = mlfs_pkg::LIMIT_RESET;
    ph      = mlfs_pkg::PH_HUNT;
    win     = '0;
    fill    = 0;
    pos     = 0;
    len_r   = '0;
    chh_r   = '0;
    chl_r   = '0;
    seq_r   = '0;
    tag_r   = '0;
    comp_r  = '0;
    lost_r  = '0;
    hit_r   = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      row = dir_tab[i];
      if (row.wr) begin
        run_and_drain();
        write_reg(row.idx, row.val);
      end else begin
        repeat (row.noise) push_beat(8'($urandom_range(1, 255)), 1'b0, '0);
        queue_frame(row.len, row.chh, row.chl, row.seqn, row.tagv, row.compw, 1'b1,
                    row.typed, row.hit, row.lost);
      end
    end
    run_and_drain();

    write_reg(mlfs_pkg::CFG_WANT_HIGH, 32'hFFFF_FFFF);
    write_reg(mlfs_pkg::CFG_WANT_LOW, 32'h0000_0000);
    write_reg(mlfs_pkg::CFG_FILTER_EN, 32'd1);
    queue_random_traffic(260);
    run_and_drain();

    quiet = 1'b1;
    write_reg(mlfs_pkg::CFG_FILTER_EN, 32'd0);
    write_reg(mlfs_pkg::CFG_MAX_LEN, $urandom_range(40, 90));
    queue_random_traffic(260);
    run_and_drain();
    quiet = 1'b0;

    write_reg(mlfs_pkg::CFG_WANT_HIGH, $urandom);
    write_reg(mlfs_pkg::CFG_WANT_LOW, $urandom);
    write_reg(mlfs_pkg::CFG_FILTER_EN, 32'd1);
    write_reg(mlfs_pkg::CFG_MAX_LEN, 32'd200);
    queue_random_traffic(270);
    run_and_drain();

    if (rec_q.size() != 0) report_mismatch("records never seen", 32'(rec_q.size()), 32'd0);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
